// ===== src/fgs_pkg.sv =====
// ----------------------------------------------------------------------------
// fgs_pkg
// Shared widths, breakpoint and reciprocal tables, rule ROMs and payload types
// for the fuzzy gain scheduler pipeline.
// ----------------------------------------------------------------------------
package fgs_pkg;

	localparam int unsigned SEG_N       = 5;
	localparam int unsigned IDX_W       = 3;
	localparam int unsigned SEG_W       = 2;
	localparam int unsigned VAL_W       = 16;
	localparam int unsigned MAG_W       = 17;
	localparam int unsigned BP_W        = 10;
	localparam int unsigned BELOW_W     = 8;
	localparam int unsigned RECIP_W     = 24;
	localparam int unsigned RECIP_SHIFT = 20;
	localparam int unsigned PROD_M_W    = 32;
	localparam int unsigned MEMB_W      = 7;
	localparam int unsigned LVL_W       = 11;
	localparam int unsigned PROD_W      = LVL_W + MEMB_W;
	localparam int unsigned NUM_W       = 20;
	localparam int unsigned DEN_W       = 9;
	localparam int unsigned TRY_W       = NUM_W + 1;
	localparam int unsigned GAIN_W      = 11;
	localparam int unsigned DIV_STEPS   = GAIN_W;
	localparam int unsigned FRONT_STAGES = 5;
	localparam int unsigned STAGES      = FRONT_STAGES + DIV_STEPS;

	localparam logic [MEMB_W-1:0] MEMB_FULL = 7'd100;
	localparam logic [IDX_W-1:0]  IDX_LAST  = 3'd4;
	localparam logic [GAIN_W-1:0] GAIN_MAX  = 11'd1900;

	typedef logic [0:SEG_N-1][BP_W-1:0]         bp_set_t;
	typedef logic [0:SEG_N-2][RECIP_W-1:0]      recip_set_t;
	typedef logic [0:SEG_N-1][LVL_W-1:0]        lvl_set_t;
	typedef logic [0:SEG_N-1][0:SEG_N-1][IDX_W-1:0] rule_rom_t;

	typedef struct packed {
		logic [IDX_W-1:0]  idx_lo;
		logic [IDX_W-1:0]  idx_hi;
		logic [MEMB_W-1:0] memb_lo;
		logic [MEMB_W-1:0] memb_hi;
	} fuzz_t;

	localparam bp_set_t ERR_BP [2] = '{
		'{10'd0, 10'd150, 10'd350, 10'd500, 10'd700},
		'{10'd0, 10'd200, 10'd300, 10'd400, 10'd500}
	};
	localparam bp_set_t RATE_BP [2] = '{
		'{10'd0, 10'd10, 10'd20, 10'd40, 10'd90},
		'{10'd0, 10'd8, 10'd16, 10'd32, 10'd64}
	};

	// ceil(100 * 2^20 / segment width)
	localparam recip_set_t ERR_RC [2] = '{
		'{24'd699051, 24'd524288, 24'd699051, 24'd524288},
		'{24'd524288, 24'd1048576, 24'd1048576, 24'd1048576}
	};
	localparam recip_set_t RATE_RC [2] = '{
		'{24'd10485760, 24'd10485760, 24'd5242880, 24'd2097152},
		'{24'd13107200, 24'd13107200, 24'd6553600, 24'd3276800}
	};

	localparam lvl_set_t LVL_P [2] = '{
		'{11'd25, 11'd40, 11'd50, 11'd60, 11'd70},
		'{11'd0, 11'd10, 11'd20, 11'd40, 11'd80}
	};
	localparam lvl_set_t LVL_D [2] = '{
		'{11'd300, 11'd700, 11'd1100, 11'd1500, 11'd1900},
		'{11'd0, 11'd20, 11'd80, 11'd200, 11'd400}
	};

	localparam rule_rom_t ROM_P [2] = '{
		'{'{3'd0, 3'd1, 3'd2, 3'd3, 3'd4}, '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4},
		  '{3'd1, 3'd1, 3'd3, 3'd3, 3'd4}, '{3'd1, 3'd2, 3'd3, 3'd4, 3'd4},
		  '{3'd2, 3'd3, 3'd3, 3'd4, 3'd4}},
		'{'{3'd0, 3'd1, 3'd2, 3'd3, 3'd4}, '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4},
		  '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4}, '{3'd1, 3'd1, 3'd2, 3'd3, 3'd4},
		  '{3'd1, 3'd2, 3'd3, 3'd3, 3'd4}}
	};
	localparam rule_rom_t ROM_D [2] = '{
		'{'{3'd0, 3'd1, 3'd1, 3'd2, 3'd2}, '{3'd0, 3'd1, 3'd1, 3'd2, 3'd2},
		  '{3'd1, 3'd1, 3'd2, 3'd3, 3'd3}, '{3'd1, 3'd2, 3'd3, 3'd3, 3'd4},
		  '{3'd2, 3'd2, 3'd3, 3'd4, 3'd4}},
		'{'{3'd0, 3'd1, 3'd1, 3'd2, 3'd2}, '{3'd0, 3'd1, 3'd2, 3'd2, 3'd3},
		  '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4}, '{3'd1, 3'd1, 3'd2, 3'd3, 3'd4},
		  '{3'd1, 3'd2, 3'd3, 3'd4, 3'd4}}
	};

	// P tables index [rate][error], D tables index [error][rate]
	function automatic logic [LVL_W-1:0] rule_level(
		input logic             prop,
		input logic             ts,
		input logic [IDX_W-1:0] xi,
		input logic [IDX_W-1:0] yi
	);
		logic [LVL_W-1:0] lvl;
		if (prop) begin
			lvl = LVL_P[ts][ROM_P[ts][yi][xi]];
		end else begin
			lvl = LVL_D[ts][ROM_D[ts][xi][yi]];
		end
		return lvl;
	endfunction

endpackage

// ===== src/fgs_fuzzify.sv =====
// ----------------------------------------------------------------------------
// fgs_fuzzify
// Two-stage placement of one signed input magnitude among five breakpoints:
// segment search, then membership by reciprocal multiplication.
// ----------------------------------------------------------------------------
module fgs_fuzzify
	import fgs_pkg::*;
(
	input  logic                    clk,
	input  logic [1:0]              en,
	input  logic signed [VAL_W-1:0] value,
	input  bp_set_t                 bp,
	input  recip_set_t              rc,
	output fuzz_t                   fuzz_s2
);

	logic [MAG_W-1:0]   ext;
	logic [MAG_W-1:0]   mag;
	logic [SEG_W-1:0]   seg;
	logic               beyond;
	logic [BP_W-1:0]    mag_n;

	logic [SEG_W-1:0]   seg_s1;
	logic               beyond_s1;
	logic [BELOW_W-1:0] below_s1;
	logic [BELOW_W-1:0] above_s1;
	logic [RECIP_W-1:0] recip_s1;

	logic [PROD_M_W-1:0] prod_hi;
	logic [PROD_M_W-1:0] prod_lo;
	fuzz_t               fuzz_n;

	always_comb begin
		ext = {value[VAL_W-1], value};
		mag = ext[MAG_W-1] ? MAG_W'(~ext + MAG_W'(1)) : ext;
		seg = '0;
		beyond = 1'b1;
		for (int k = SEG_N - 1; k >= 1; k--) begin
			if (mag <= MAG_W'(bp[k])) begin
				seg = SEG_W'(k - 1);
				beyond = 1'b0;
			end
		end
		mag_n = mag[BP_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			seg_s1    <= seg;
			beyond_s1 <= beyond;
			below_s1  <= BELOW_W'(mag_n - bp[{1'b0, seg}]);
			above_s1  <= BELOW_W'(bp[IDX_W'({1'b0, seg}) + IDX_W'(1)] - mag_n);
			recip_s1  <= rc[seg];
		end
	end

	always_comb begin
		prod_hi = PROD_M_W'(below_s1) * PROD_M_W'(recip_s1);
		prod_lo = PROD_M_W'(above_s1) * PROD_M_W'(recip_s1);
		if (beyond_s1) begin
			fuzz_n.idx_lo  = IDX_LAST;
			fuzz_n.idx_hi  = IDX_LAST;
			fuzz_n.memb_lo = MEMB_FULL;
			fuzz_n.memb_hi = MEMB_FULL;
		end else begin
			fuzz_n.idx_lo  = {1'b0, seg_s1};
			fuzz_n.idx_hi  = IDX_W'({1'b0, seg_s1}) + IDX_W'(1);
			fuzz_n.memb_lo = prod_lo[RECIP_SHIFT +: MEMB_W];
			fuzz_n.memb_hi = prod_hi[RECIP_SHIFT +: MEMB_W];
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			fuzz_s2 <= fuzz_n;
		end
	end

endmodule

// ===== src/fgs_rules.sv =====
// ----------------------------------------------------------------------------
// fgs_rules
// Minimum inference over four rule cells, rule ROM lookup, weighted products
// and the numerator and weight sums.
// ----------------------------------------------------------------------------
module fgs_rules
	import fgs_pkg::*;
(
	input  logic             clk,
	input  logic [2:0]       en,
	input  fuzz_t            err,
	input  fuzz_t            rate,
	input  logic             prop,
	input  logic             ts,
	output logic [NUM_W-1:0] num_s5,
	output logic [DEN_W-1:0] den_s5
);

	logic [LVL_W-1:0]  u_s3 [4];
	logic [MEMB_W-1:0] w_s3 [4];
	logic [PROD_W-1:0] p_s4 [4];
	logic [DEN_W-1:0]  den_s4;

	function automatic logic [MEMB_W-1:0] min_m(
		input logic [MEMB_W-1:0] a,
		input logic [MEMB_W-1:0] b
	);
		return (a <= b) ? a : b;
	endfunction

	always_ff @(posedge clk) begin
		if (en[0]) begin
			u_s3[0] <= rule_level(prop, ts, err.idx_lo, rate.idx_lo);
			u_s3[1] <= rule_level(prop, ts, err.idx_lo, rate.idx_hi);
			u_s3[2] <= rule_level(prop, ts, err.idx_hi, rate.idx_lo);
			u_s3[3] <= rule_level(prop, ts, err.idx_hi, rate.idx_hi);
			w_s3[0] <= min_m(err.memb_lo, rate.memb_lo);
			w_s3[1] <= min_m(err.memb_lo, rate.memb_hi);
			w_s3[2] <= min_m(err.memb_hi, rate.memb_lo);
			w_s3[3] <= min_m(err.memb_hi, rate.memb_hi);
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			for (int i = 0; i < 4; i++) begin
				p_s4[i] <= PROD_W'(u_s3[i]) * PROD_W'(w_s3[i]);
			end
			den_s4 <= DEN_W'(w_s3[0]) + DEN_W'(w_s3[1]) + DEN_W'(w_s3[2]) + DEN_W'(w_s3[3]);
		end
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			num_s5 <= NUM_W'(p_s4[0]) + NUM_W'(p_s4[1]) + NUM_W'(p_s4[2]) + NUM_W'(p_s4[3]);
			den_s5 <= den_s4;
		end
	end

endmodule

// ===== src/fgs_divider.sv =====
// ----------------------------------------------------------------------------
// fgs_divider
// Pipelined restoring divider, one quotient bit per stage, giving the
// truncated weighted average; a zero weight sum gives zero.
// ----------------------------------------------------------------------------
module fgs_divider
	import fgs_pkg::*;
(
	input  logic                 clk,
	input  logic [DIV_STEPS-1:0] en,
	input  logic [NUM_W-1:0]     num,
	input  logic [DEN_W-1:0]     den,
	output logic [GAIN_W-1:0]    gain
);

	logic [NUM_W-1:0]  rem_s [DIV_STEPS];
	logic [DEN_W-1:0]  den_s [DIV_STEPS];
	logic [GAIN_W-1:0] quo_s [DIV_STEPS];

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
		localparam int unsigned SH = DIV_STEPS - 1 - k;
		logic [NUM_W-1:0]  rem_in;
		logic [DEN_W-1:0]  den_in;
		logic [GAIN_W-1:0] quo_in;
		logic [TRY_W-1:0]  trial;
		logic              take;

		if (k == 0) begin : g_first
			assign rem_in = num;
			assign den_in = den;
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign den_in = den_s[k-1];
			assign quo_in = quo_s[k-1];
		end

		assign trial = TRY_W'(den_in) << SH;
		assign take  = {1'b0, rem_in} >= trial;

		always_ff @(posedge clk) begin
			if (en[k]) begin
				rem_s[k] <= take ? NUM_W'({1'b0, rem_in} - trial) : rem_in;
				den_s[k] <= den_in;
				quo_s[k] <= {quo_in[GAIN_W-2:0], take};
			end
		end
	end

	assign gain = (den_s[DIV_STEPS-1] == '0) ? '0 : quo_s[DIV_STEPS-1];

endmodule

// ===== src/fuzzy_gain_scheduler_core.sv =====
// ----------------------------------------------------------------------------
// fuzzy_gain_scheduler_core
// Fuzzy PD gain scheduler: magnitude placement, min inference over four rule
// cells, rule ROM lookup and weighted-average defuzzification.
//
// Channel   Dir  Width  Contents
// s_axis    in   32+2   tdata: error_value, error_rate; tuser: gain_select, table_set
// m_axis    out  16     tdata: gain_out
//
// One beat in per cycle unless the output stalls; 2 fuzzify, 3 rule and
// sum, 11 divider stages, one quotient bit each.
// Every stage holds a valid bit; a stage advances when it is empty or the
// stage after it advances, so bubbles close up under a stall.
// arst_n clears all valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
module fuzzy_gain_scheduler_core
	import fgs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // [15:0] error_value, [31:16] error_rate
	input  logic [1:0]  s_axis_tuser,   // [0] gain_select, [1] table_set
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata    // [10:0] gain_out
);

	logic [STAGES-1:0] vld_s;
	logic [STAGES-1:0] en;

	logic              gsel_s1;
	logic              ts_s1;
	logic              gsel_s2;
	logic              ts_s2;
	logic              ts_in;

	fuzz_t             err_s2;
	fuzz_t             rate_s2;
	logic [NUM_W-1:0]  num_s5;
	logic [DEN_W-1:0]  den_s5;
	logic [GAIN_W-1:0] gain;

	assign ts_in = s_axis_tuser[1];

	assign en[STAGES-1] = !vld_s[STAGES-1] || m_axis_tready;
	for (genvar i = 0; i < STAGES - 1; i++) begin : g_en
		assign en[i] = !vld_s[i] || en[i+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (en[0]) begin
				vld_s[0] <= s_axis_tvalid;
			end
			for (int i = 1; i < STAGES; i++) begin
				if (en[i]) begin
					vld_s[i] <= vld_s[i-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			gsel_s1 <= s_axis_tuser[0];
			ts_s1   <= ts_in;
		end
		if (en[1]) begin
			gsel_s2 <= gsel_s1;
			ts_s2   <= ts_s1;
		end
	end

	fgs_fuzzify u_err (
		.clk     (clk),
		.en      (en[1:0]),
		.value   (s_axis_tdata[15:0]),
		.bp      (ERR_BP[ts_in]),
		.rc      (ERR_RC[ts_in]),
		.fuzz_s2 (err_s2)
	);

	fgs_fuzzify u_rate (
		.clk     (clk),
		.en      (en[1:0]),
		.value   (s_axis_tdata[31:16]),
		.bp      (RATE_BP[ts_in]),
		.rc      (RATE_RC[ts_in]),
		.fuzz_s2 (rate_s2)
	);

	fgs_rules u_rules (
		.clk    (clk),
		.en     (en[4:2]),
		.err    (err_s2),
		.rate   (rate_s2),
		.prop   (gsel_s2),
		.ts     (ts_s2),
		.num_s5 (num_s5),
		.den_s5 (den_s5)
	);

	fgs_divider u_div (
		.clk  (clk),
		.en   (en[STAGES-1:FRONT_STAGES]),
		.num  (num_s5),
		.den  (den_s5),
		.gain (gain)
	);

	assign s_axis_tready = en[0];
	assign m_axis_tvalid = vld_s[STAGES-1];
	assign m_axis_tdata  = {(16 - GAIN_W)'(0), gain};

	a_gain_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (gain <= GAIN_MAX))
		else $error("gain above largest output level");

	a_accept_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> vld_s[0])
		else $error("accepted beat missing from first stage");

	a_blocked_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (&vld_s))
		else $error("input blocked while pipeline has a bubble");

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stream-level check of fuzzy_gain_scheduler_core. A queue of planned beats
// feeds a clocked driver; every accepted beat is scored by an independent
// fuzzify / min-inference / weighted-average model. A clocked monitor compares
// each output beat with the oldest predicted gain. Both sides idle at random,
// the output is held off for a long stretch to back the pipeline up, and the
// input is paused until the pipeline has emptied.
// ----------------------------------------------------------------------------
module tb;

	typedef enum logic [1:0] {K_BEAT, K_MODE, K_HOLD, K_DRAIN} plan_kind_t;

	typedef struct {
		plan_kind_t  kind;
		logic [15:0] err;
		logic [15:0] rate;
		logic        prop;
		logic        ts;
		int          tx_pct;
		int          rx_pct;
	} plan_t;

	localparam int unsigned FULL_SCALE = 100;
	localparam int          HOLD_CYCLES = 300;
	localparam int          SETTLE_CYCLES = 40;

	localparam logic [0:1][0:4][10:0] ERR_KNOTS = {
		11'd0, 11'd150, 11'd350, 11'd500, 11'd700,
		11'd0, 11'd200, 11'd300, 11'd400, 11'd500
	};
	localparam logic [0:1][0:4][10:0] RATE_KNOTS = {
		11'd0, 11'd10, 11'd20, 11'd40, 11'd90,
		11'd0, 11'd8, 11'd16, 11'd32, 11'd64
	};
	localparam logic [0:1][0:4][10:0] P_LEVELS = {
		11'd25, 11'd40, 11'd50, 11'd60, 11'd70,
		11'd0, 11'd10, 11'd20, 11'd40, 11'd80
	};
	localparam logic [0:1][0:4][10:0] D_LEVELS = {
		11'd300, 11'd700, 11'd1100, 11'd1500, 11'd1900,
		11'd0, 11'd20, 11'd80, 11'd200, 11'd400
	};
	// P rules are [rate][error], D rules are [error][rate]
	localparam logic [0:1][0:4][0:4][3:0] P_RULES =
		200'h01234_01234_11334_12344_23344_01234_01234_01234_11234_12334;
	localparam logic [0:1][0:4][0:4][3:0] D_RULES =
		200'h01122_01122_11233_12334_22344_01122_01223_01234_11234_12344;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;
	logic [1:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;

	plan_t       plan_q[$];
	logic [10:0] gain_q[$];
	int          tx_idle_pct = 0;
	int          rx_idle_pct = 0;
	int          hold_reqs = 0;
	int          hold_done = 0;
	int          hold_left = 0;
	int          err_cnt = 0;

	fuzzy_gain_scheduler_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	function automatic int unsigned abs16(input logic [15:0] v);
		if (v[15]) begin
			return 32'd65536 - {16'd0, v};
		end
		return {16'd0, v};
	endfunction

	function automatic int unsigned umin(input int unsigned a, input int unsigned b);
		return (a <= b) ? a : b;
	endfunction

	function automatic void fuzzify(
		input  int unsigned        m,
		input  logic [0:4][10:0]   knots,
		output int unsigned        lo,
		output int unsigned        hi,
		output int unsigned        mlo,
		output int unsigned        mhi
	);
		int unsigned span;
		int unsigned below;
		lo = 4;
		hi = 4;
		mlo = FULL_SCALE;
		mhi = FULL_SCALE;
		for (int k = 1; k < 5; k++) begin
			if (m <= knots[k]) begin
				span = knots[k] - knots[k-1];
				below = (m > knots[k-1]) ? (m - knots[k-1]) : 0;
				lo = k - 1;
				hi = k;
				mhi = (FULL_SCALE * below) / span;
				mlo = (FULL_SCALE * (knots[k] - m)) / span;
				return;
			end
		end
	endfunction

	function automatic logic [10:0] expected_gain(
		input logic [15:0] err,
		input logic [15:0] rate,
		input logic        prop,
		input logic        ts
	);
		int unsigned xl, xh, yl, yh, exl, exh, eyl, eyh;
		int unsigned wt[4];
		int unsigned lv[4];
		int unsigned num;
		int unsigned den;
		fuzzify(abs16(err), ERR_KNOTS[ts], xl, xh, exl, exh);
		fuzzify(abs16(rate), RATE_KNOTS[ts], yl, yh, eyl, eyh);
		wt[0] = umin(exl, eyl);
		wt[1] = umin(exl, eyh);
		wt[2] = umin(exh, eyl);
		wt[3] = umin(exh, eyh);
		if (prop) begin
			lv[0] = P_LEVELS[ts][P_RULES[ts][yl][xl]];
			lv[1] = P_LEVELS[ts][P_RULES[ts][yh][xl]];
			lv[2] = P_LEVELS[ts][P_RULES[ts][yl][xh]];
			lv[3] = P_LEVELS[ts][P_RULES[ts][yh][xh]];
		end else begin
			lv[0] = D_LEVELS[ts][D_RULES[ts][xl][yl]];
			lv[1] = D_LEVELS[ts][D_RULES[ts][xl][yh]];
			lv[2] = D_LEVELS[ts][D_RULES[ts][xh][yl]];
			lv[3] = D_LEVELS[ts][D_RULES[ts][xh][yh]];
		end
		num = 0;
		den = 0;
		for (int i = 0; i < 4; i++) begin
			num += lv[i] * wt[i];
			den += wt[i];
		end
		return (den != 0) ? 11'(num / den) : 11'd0;
	endfunction

	task automatic flag_mismatch(input string what, input logic [15:0] got,
		input logic [15:0] want);
		$display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
		err_cnt++;
	endtask

	task automatic add_beat(input int err, input int rate, input logic prop, input logic ts);
		plan_t p;
		p.kind = K_BEAT;
		p.err = 16'(err);
		p.rate = 16'(rate);
		p.prop = prop;
		p.ts = ts;
		p.tx_pct = 0;
		p.rx_pct = 0;
		plan_q.push_back(p);
	endtask

	task automatic add_marker(input plan_kind_t kind, input int tx_pct, input int rx_pct);
		plan_t p;
		p.kind = kind;
		p.err = '0;
		p.rate = '0;
		p.prop = 1'b0;
		p.ts = 1'b0;
		p.tx_pct = tx_pct;
		p.rx_pct = rx_pct;
		plan_q.push_back(p);
	endtask

	task automatic add_random(input int n);
		int          e;
		int          r;
		logic        ts;
		int unsigned pick;
		for (int i = 0; i < n; i++) begin
			ts = 1'($urandom_range(1));
			pick = $urandom_range(9);
			if (pick < 6) begin
				e = $urandom_range(760);
				r = $urandom_range(100);
			end else if (pick == 6) begin
				e = ERR_KNOTS[ts][$urandom_range(4)] + $urandom_range(2) - 1;
				r = RATE_KNOTS[ts][$urandom_range(4)] + $urandom_range(2) - 1;
			end else begin
				e = $urandom;
				r = $urandom;
			end
			if ($urandom_range(1)) begin
				e = -e;
			end
			if ($urandom_range(1)) begin
				r = -r;
			end
			add_beat(e, r, 1'($urandom_range(1)), ts);
		end
	endtask

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("FAILURE");
		$finish;
	end

	initial begin
		add_marker(K_MODE, 34, 73);
		for (int c = 0; c < 4; c++) begin
			add_beat(0, 0, c[0], c[1]);
			add_beat(-32768, 32767, c[0], c[1]);
		end
		add_beat(-1, 1, 1'b1, 1'b0);
		add_beat(1, -1, 1'b0, 1'b1);
		add_beat(150, 10, 1'b1, 1'b0);
		add_beat(-151, -11, 1'b0, 1'b0);
		add_beat(700, 90, 1'b0, 1'b0);
		add_beat(701, -91, 1'b1, 1'b0);
		add_beat(-700, 45, 1'b0, 1'b0);
		add_beat(200, 8, 1'b0, 1'b1);
		add_beat(-201, -9, 1'b1, 1'b1);
		add_beat(500, 64, 1'b1, 1'b1);
		add_beat(501, 65, 1'b0, 1'b1);
		add_beat(499, 63, 1'b0, 1'b1);
		add_beat(32767, -32768, 1'b1, 1'b1);
		add_random(700);
		add_marker(K_DRAIN, 0, 0);
		add_marker(K_MODE, 73, 34);
		add_random(700);
		add_marker(K_MODE, 0, 0);
		add_marker(K_HOLD, 0, 0);
		add_random(200);
		add_marker(K_DRAIN, 0, 0);
		add_random(400);

		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (plan_q.size() != 0 || s_axis_tvalid) @(posedge clk);
		while (gain_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (err_cnt == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	always @(posedge clk or negedge arst_n) begin
		plan_t nxt;
		logic  waiting;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tuser <= '0;
			hold_reqs = 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				gain_q.push_back(expected_gain(s_axis_tdata[15:0], s_axis_tdata[31:16],
					s_axis_tuser[0], s_axis_tuser[1]));
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				waiting = 1'b0;
				while (plan_q.size() != 0 && plan_q[0].kind != K_BEAT && !waiting) begin
					case (plan_q[0].kind)
					K_MODE: begin
						tx_idle_pct = plan_q[0].tx_pct;
						rx_idle_pct = plan_q[0].rx_pct;
						void'(plan_q.pop_front());
					end
					K_HOLD: begin
						hold_reqs++;
						void'(plan_q.pop_front());
					end
					K_DRAIN: begin
						if (gain_q.size() == 0) begin
							void'(plan_q.pop_front());
						end else begin
							waiting = 1'b1;
						end
					end
					default: begin
						void'(plan_q.pop_front());
					end
					endcase
				end
				if (!waiting && plan_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
					nxt = plan_q.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= {nxt.rate, nxt.err};
					s_axis_tuser <= {nxt.ts, nxt.prop};
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		logic [10:0] want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			hold_left = 0;
			hold_done = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (gain_q.size() == 0) begin
					flag_mismatch("unexpected beat", m_axis_tdata, 16'd0);
				end else begin
					want = gain_q.pop_front();
					if (m_axis_tdata !== {5'd0, want}) begin
						flag_mismatch("gain_out", m_axis_tdata, {5'd0, want});
					end
				end
			end
			if (hold_done != hold_reqs) begin
				hold_done++;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

endmodule
